### rtl/lowest_free_key_table_core_assert.svh
// Assertion macros for the lowest free key table core.
// The assertions run on clk and are disabled while arst_n is low.
`ifndef LOWEST_FREE_KEY_TABLE_CORE_ASSERT_SVH
`define LOWEST_FREE_KEY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LFKT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lowest_free_key_table_core: assertion failed");
`define LFKT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lowest_free_key_table_core: assertion failed");
`else
`define LFKT_ASSERT_IMP(lbl, ante, cons)
`define LFKT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/lfkt_pkg.sv
`timescale 1ns / 1ps
package lfkt_pkg;

	localparam int unsigned ENTRIES    = 256;
	localparam int unsigned VALUE_BITS = 32;

	// key space is padded to a power of two; padding slots read as occupied
	localparam int unsigned KEY_BITS  = ($clog2(ENTRIES) < 2) ? 2 : $clog2(ENTRIES);
	localparam int unsigned SLOT_SPAN = 1 << KEY_BITS;
	localparam int unsigned HI_BITS   = KEY_BITS / 2;
	localparam int unsigned LO_BITS   = KEY_BITS - HI_BITS;
	localparam int unsigned HI_SIZE   = 1 << HI_BITS;
	localparam int unsigned LO_SIZE   = 1 << LO_BITS;
	localparam int unsigned RAM_DEPTH = SLOT_SPAN;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_EMPTY_KEY  = 2'd2;
	localparam logic [1:0] ST_ZERO_VALUE = 2'd3;

	typedef logic [KEY_BITS-1:0]   key_idx_t;
	typedef logic [HI_BITS-1:0]    hi_idx_t;
	typedef logic [LO_BITS-1:0]    lo_idx_t;
	typedef logic [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0]  assigned_key;
		logic [31:0] read_value;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic    found;
		lo_idx_t idx;
	} enc_res_t;

	function automatic val_t in_value(logic [31:0] v);
		logic [VALUE_BITS+31:0] w;
		w = {{VALUE_BITS{1'b0}}, v};
		return w[VALUE_BITS-1:0];
	endfunction

	function automatic logic [31:0] out_value(val_t v);
		logic [VALUE_BITS+31:0] w;
		w = {32'b0, v};
		return w[31:0];
	endfunction

	function automatic key_idx_t key_index(logic [7:0] k);
		logic [KEY_BITS+7:0] w;
		w = {{KEY_BITS{1'b0}}, k};
		return w[KEY_BITS-1:0];
	endfunction

	function automatic logic [7:0] out_key(key_idx_t k);
		logic [KEY_BITS+7:0] w;
		w = {8'b0, k};
		return w[7:0];
	endfunction

	function automatic logic key_in_range(logic [7:0] k);
		return {24'b0, k} < 32'(ENTRIES);
	endfunction

endpackage

### rtl/lfkt_ram.sv
`timescale 1ns / 1ps
module lfkt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/lfkt_lzenc.sv
`timescale 1ns / 1ps
// lowest clear bit of one group; shared by both search steps
module lfkt_lzenc (
	input  logic [lfkt_pkg::LO_SIZE-1:0] bits,
	output lfkt_pkg::enc_res_t           res
);

	always_comb begin
		res.found = ~&bits;
		res.idx   = '0;
		for (int i = lfkt_pkg::LO_SIZE - 1; i >= 0; i--) begin
			if (!bits[i]) begin
				res.idx = lfkt_pkg::lo_idx_t'(i);
			end
		end
	end

endmodule

### rtl/lowest_free_key_table_core.sv
// Lowest free key table: insert at lowest empty key, lookup, remove, clear.
// Lookup, remove, clear and zero-value insert: result in the cycle after accept.
// Insert: group search, then slot search, then result; the slot search is skipped
// when every group is full. busy drops in the result cycle, so a new item
// can be taken there. arst_n empties every slot at once; value memory is not reset.
`timescale 1ns / 1ps
`include "lowest_free_key_table_core_assert.svh"
module lowest_free_key_table_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lfkt_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output lfkt_pkg::rsp_t  rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HI   = 2'd1;
	localparam logic [1:0] S_LO   = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0]                      state_q;
	logic [lfkt_pkg::ENTRIES-1:0]    occ_q;
	logic [lfkt_pkg::SLOT_SPAN-1:0]  occ_pad;
	logic [lfkt_pkg::LO_SIZE-1:0]    grp_full;
	logic [lfkt_pkg::LO_SIZE-1:0]    enc_in;
	lfkt_pkg::enc_res_t              enc;
	lfkt_pkg::hi_idx_t               hi_q;
	lfkt_pkg::val_t                  value_q;
	lfkt_pkg::key_idx_t              ins_key_q;
	logic [1:0]                      op_q;
	logic [7:0]                      akey_q;
	logic [1:0]                      status_q;
	logic                            hit_q;
	logic                            acc;
	lfkt_pkg::key_idx_t              req_idx;
	logic                            req_hit;
	lfkt_pkg::val_t                  req_val;
	lfkt_pkg::key_idx_t              new_key;
	logic                            ram_we;
	lfkt_pkg::val_t                  ram_rdata;

	assign busy    = (state_q == S_HI) || (state_q == S_LO);
	assign done    = (state_q == S_RESP);
	assign acc     = start && !busy;
	assign req_idx = lfkt_pkg::key_index(req.key);
	assign req_val = lfkt_pkg::in_value(req.value);
	assign req_hit = lfkt_pkg::key_in_range(req.key) && occ_pad[req_idx];
	assign new_key = {hi_q, enc.idx};
	assign ram_we  = (state_q == S_LO);

	always_comb begin
		occ_pad = '1;
		occ_pad[lfkt_pkg::ENTRIES-1:0] = occ_q;
	end

	always_comb begin
		grp_full = '1;
		for (int g = 0; g < lfkt_pkg::HI_SIZE; g++) begin
			grp_full[g] = &occ_pad[g*lfkt_pkg::LO_SIZE +: lfkt_pkg::LO_SIZE];
		end
	end

	assign enc_in = (state_q == S_HI) ? grp_full
		: occ_pad[{hi_q, {lfkt_pkg::LO_BITS{1'b0}}} +: lfkt_pkg::LO_SIZE];

	lfkt_lzenc u_enc (
		.bits (enc_in),
		.res  (enc)
	);

	lfkt_ram #(
		.WIDTH (lfkt_pkg::VALUE_BITS),
		.DEPTH (lfkt_pkg::RAM_DEPTH)
	) u_values (
		.clk   (clk),
		.we    (ram_we),
		.waddr (new_key),
		.wdata (value_q),
		.re    (acc && (req.opcode == lfkt_pkg::OP_LOOKUP)),
		.raddr (req_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			hi_q      <= '0;
			value_q   <= '0;
			ins_key_q <= '0;
			op_q      <= lfkt_pkg::OP_INSERT;
			akey_q    <= '0;
			status_q  <= lfkt_pkg::ST_OK;
			hit_q     <= 1'b0;
		end else if (acc) begin
			op_q     <= req.opcode;
			value_q  <= req_val;
			akey_q   <= '0;
			hit_q    <= 1'b0;
			status_q <= lfkt_pkg::ST_OK;
			state_q  <= S_RESP;
			unique case (req.opcode)
				lfkt_pkg::OP_INSERT: begin
					if (req_val == '0) begin
						status_q <= lfkt_pkg::ST_ZERO_VALUE;
					end else begin
						state_q <= S_HI;
					end
				end
				lfkt_pkg::OP_LOOKUP: begin
					hit_q <= req_hit;
				end
				lfkt_pkg::OP_REMOVE: begin
					if (req_hit) begin
						occ_q[req_idx] <= 1'b0;
					end else begin
						status_q <= lfkt_pkg::ST_EMPTY_KEY;
					end
				end
				lfkt_pkg::OP_CLEAR: begin
					occ_q <= '0;
				end
				default: begin
					state_q <= S_RESP;
				end
			endcase
		end else begin
			unique case (state_q)
				S_HI: begin
					if (enc.found) begin
						hi_q    <= enc.idx[lfkt_pkg::HI_BITS-1:0];
						state_q <= S_LO;
					end else begin
						status_q <= lfkt_pkg::ST_FULL;
						state_q  <= S_RESP;
					end
				end
				S_LO: begin
					occ_q[new_key] <= 1'b1;
					ins_key_q      <= new_key;
					akey_q         <= lfkt_pkg::out_key(new_key);
					state_q        <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp.assigned_key = akey_q;
		rsp.read_value   = hit_q ? lfkt_pkg::out_value(ram_rdata) : 32'b0;
		rsp.status       = status_q;
	end

	`LFKT_ASSERT_NXT(a_accept_progress, acc, busy || done)
	`LFKT_ASSERT_IMP(a_group_has_room, state_q == S_LO, enc.found)
	`LFKT_ASSERT_IMP(a_full_means_full, done && (status_q == lfkt_pkg::ST_FULL), &occ_q)
	`LFKT_ASSERT_IMP(a_insert_marked,
		done && (op_q == lfkt_pkg::OP_INSERT) && (status_q == lfkt_pkg::ST_OK),
		occ_pad[ins_key_q])

endmodule
